// ===== design/csr_bds_pkg.sv =====
// ----------------------------------------------------------------------------
// csr_bds_pkg
// shared types and constants of the block-diagonal splitter
// ----------------------------------------------------------------------------
package csr_bds_pkg;

  // default configuration of the splitter
  localparam int unsigned DefRowBufferDepth = 32;
  localparam int unsigned DefIndexBits      = 16;

  // fixed field widths
  localparam int unsigned ColW  = 16;
  localparam int unsigned ValW  = 64;
  localparam int unsigned RowW  = 16;
  localparam int unsigned DcntW = 6;
  localparam int unsigned RcntW = 16;
  localparam int unsigned BsW   = 16;
  localparam int unsigned KindW = 2;

  // buffered entry: column plus both value words
  localparam int unsigned EntryW = ColW + 2 * ValW;

  // input command codes
  localparam logic CMD_ENTRY   = 1'b0;
  localparam logic CMD_ROW_END = 1'b1;

  // result kinds
  localparam logic [KindW-1:0] KIND_DIAG    = 2'd0;
  localparam logic [KindW-1:0] KIND_REST    = 2'd1;
  localparam logic [KindW-1:0] KIND_SUMMARY = 2'd2;

  localparam logic [DcntW-1:0] DcntMax = '1;
  localparam logic [RcntW-1:0] RcntMax = '1;

  // controller to datapath
  typedef struct packed {
    logic accept;       // input transaction taken this cycle
    logic load_diag;    // put held diagonal element in output register
    logic rd_en;        // issue buffer read at read index
    logic load_entry;   // put buffer read data in output register
    logic load_summary; // put row summary in output register
    logic row_advance;  // close the row and move to the next
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic diag_valid;   // a diagonal element is held for this row
    logic rd_more;      // buffered entries still to be read
  } status_t;

endpackage

// ===== design/csr_bds_ram.sv =====
// ----------------------------------------------------------------------------
// csr_bds_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module csr_bds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/csr_bds_ctrl.sv =====
// ----------------------------------------------------------------------------
// csr_bds_ctrl
// sequencer: takes transactions and walks the row-end drain
// ----------------------------------------------------------------------------
module csr_bds_ctrl
  import csr_bds_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    command_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIAG,
    S_READ,
    S_DATA,
    S_SUM
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o   = !status_i.out_free;
        cmd_o.accept = in_valid_i && status_i.out_free;
        if (cmd_o.accept && (command_i == CMD_ROW_END)) begin
          state_d = S_DIAG;
        end
      end
      S_DIAG: begin
        if (!status_i.diag_valid) begin
          state_d = S_READ;
        end else if (status_i.out_free) begin
          cmd_o.load_diag = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        if (status_i.rd_more) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_DATA;
        end else begin
          state_d = S_SUM;
        end
      end
      S_DATA: begin
        if (status_i.out_free) begin
          cmd_o.load_entry = 1'b1;
          state_d          = S_READ;
        end
      end
      S_SUM: begin
        if (status_i.out_free) begin
          cmd_o.load_summary = 1'b1;
          cmd_o.row_advance  = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/csr_bds_datapath.sv =====
// ----------------------------------------------------------------------------
// csr_bds_datapath
// row state, entry classification, row buffer and output register
// ----------------------------------------------------------------------------
module csr_bds_datapath
  import csr_bds_pkg::*;
#(
  parameter int unsigned ROW_BUFFER_DEPTH = DefRowBufferDepth,
  parameter int unsigned INDEX_BITS       = DefIndexBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [BsW-1:0]   cfg_wdata_i,
  input  logic             command_i,
  input  logic [ColW-1:0]  column_i,
  input  logic [ValW-1:0]  value_real_i,
  input  logic [ValW-1:0]  value_imag_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [KindW-1:0] kind_o,
  output logic [ColW-1:0]  out_column_o,
  output logic [ValW-1:0]  out_real_o,
  output logic [ValW-1:0]  out_imag_o,
  output logic [RowW-1:0]  out_row_o,
  output logic [DcntW-1:0] diag_count_o,
  output logic [RcntW-1:0] rest_count_o,
  output logic             overflow_o,
  output logic             last_o
);

  localparam int unsigned AW   = (ROW_BUFFER_DEPTH > 1) ? $clog2(ROW_BUFFER_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(ROW_BUFFER_DEPTH + 1);
  // compare width wide enough for row, column and block end
  localparam int unsigned CW   = ((INDEX_BITS > BsW) ? INDEX_BITS : BsW) + 1;

  // configuration and row state
  logic [BsW-1:0]        block_size_q;
  logic [INDEX_BITS-1:0] current_row_q, block_start_q;
  logic [CNTW-1:0]       pending_count_q, rd_idx_q;
  logic                  diag_valid_q, overflow_seen_q;
  logic [ValW-1:0]       diag_real_q, diag_imag_q;
  logic [RcntW-1:0]      rest_row_count_q;

  // output register
  logic                  out_valid_q;
  logic [KindW-1:0]      kind_q;
  logic [ColW-1:0]       out_column_q;
  logic [ValW-1:0]       out_real_q, out_imag_q;
  logic [RowW-1:0]       out_row_q;
  logic [DcntW-1:0]      diag_count_q;
  logic [RcntW-1:0]      rest_count_q;
  logic                  overflow_q, last_q;

  logic [BsW-1:0]        bs_eff;
  logic [CW-1:0]         col_x, start_x, bs_x, row_x, next_x;
  logic                  in_block, is_entry, take_rest, take_diag, buf_full;
  logic                  buf_write;
  logic [INDEX_BITS-1:0] next_row, block_start_d;
  logic [6:0]            dsum;
  logic [DcntW-1:0]      dcnt;
  logic [EntryW-1:0]     rdata;
  logic                  out_free, any_load;

  assign bs_eff   = (block_size_q == '0) ? BsW'(1) : block_size_q;
  assign col_x    = CW'(column_i);
  assign start_x  = CW'(block_start_q);
  assign bs_x     = CW'(bs_eff);
  assign row_x    = CW'(current_row_q);
  assign in_block = (col_x >= start_x) && (col_x < start_x + bs_x);

  assign is_entry  = cmd_i.accept && (command_i == CMD_ENTRY);
  assign take_rest = is_entry && !in_block;
  assign take_diag = is_entry && in_block && (col_x == row_x) && !diag_valid_q;
  assign buf_full  = (pending_count_q == CNTW'(ROW_BUFFER_DEPTH));
  assign buf_write = is_entry && in_block && !take_diag && !buf_full;

  // next row and its block start
  assign next_row = current_row_q + INDEX_BITS'(1);
  assign next_x   = CW'(next_row);
  always_comb begin
    block_start_d = block_start_q;
    if (next_row == '0) begin
      block_start_d = '0;
    end else if ((next_x >= start_x) && ((next_x - start_x) >= bs_x)) begin
      block_start_d = next_row;
    end else if (next_x < start_x) begin
      block_start_d = next_row;
    end
  end

  // saturating diagonal count
  assign dsum = 7'(pending_count_q) + 7'(diag_valid_q);
  assign dcnt = (dsum > 7'(DcntMax)) ? DcntMax : dsum[DcntW-1:0];

  csr_bds_ram #(
    .WIDTH (EntryW),
    .DEPTH (ROW_BUFFER_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_write),
    .waddr_i (pending_count_q[AW-1:0]),
    .wdata_i ({column_i, value_real_i, value_imag_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign any_load = take_rest || cmd_i.load_diag || cmd_i.load_entry || cmd_i.load_summary;

  assign status_o.out_free   = out_free;
  assign status_o.diag_valid = diag_valid_q;
  assign status_o.rd_more    = (rd_idx_q < pending_count_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q     <= BsW'(1);
      current_row_q    <= '0;
      block_start_q    <= '0;
      pending_count_q  <= '0;
      rd_idx_q         <= '0;
      diag_valid_q     <= 1'b0;
      diag_real_q      <= '0;
      diag_imag_q      <= '0;
      rest_row_count_q <= '0;
      overflow_seen_q  <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        block_size_q <= cfg_wdata_i;
      end
      if (take_rest && (rest_row_count_q != RcntMax)) begin
        rest_row_count_q <= rest_row_count_q + RcntW'(1);
      end
      if (take_diag) begin
        diag_valid_q <= 1'b1;
        diag_real_q  <= value_real_i;
        diag_imag_q  <= value_imag_i;
      end
      if (buf_write) begin
        pending_count_q <= pending_count_q + CNTW'(1);
      end
      if (is_entry && in_block && !take_diag && buf_full) begin
        overflow_seen_q <= 1'b1;
      end
      if (cmd_i.load_entry) begin
        rd_idx_q <= rd_idx_q + CNTW'(1);
      end
      if (cmd_i.row_advance) begin
        current_row_q    <= next_row;
        block_start_q    <= block_start_d;
        pending_count_q  <= '0;
        rd_idx_q         <= '0;
        diag_valid_q     <= 1'b0;
        rest_row_count_q <= '0;
        overflow_seen_q  <= 1'b0;
      end
      if (any_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (any_load) begin
      out_row_q    <= RowW'(current_row_q);
      out_column_q <= '0;
      out_real_q   <= '0;
      out_imag_q   <= '0;
      diag_count_q <= '0;
      rest_count_q <= '0;
      overflow_q   <= 1'b0;
      last_q       <= 1'b0;
      kind_q       <= KIND_DIAG;
      if (take_rest) begin
        kind_q       <= KIND_REST;
        out_column_q <= column_i;
        out_real_q   <= value_real_i;
        out_imag_q   <= value_imag_i;
        last_q       <= 1'b1;
      end else if (cmd_i.load_diag) begin
        out_column_q <= ColW'(current_row_q);
        out_real_q   <= diag_real_q;
        out_imag_q   <= diag_imag_q;
      end else if (cmd_i.load_entry) begin
        {out_column_q, out_real_q, out_imag_q} <= rdata;
      end else begin
        kind_q       <= KIND_SUMMARY;
        diag_count_q <= dcnt;
        rest_count_q <= rest_row_count_q;
        overflow_q   <= overflow_seen_q;
        last_q       <= 1'b1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign out_column_o = out_column_q;
  assign out_real_o   = out_real_q;
  assign out_imag_o   = out_imag_q;
  assign out_row_o    = out_row_q;
  assign diag_count_o = diag_count_q;
  assign rest_count_o = rest_count_q;
  assign overflow_o   = overflow_q;
  assign last_o       = last_q;

  // buffer fill never passes its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_count_q <= CNTW'(ROW_BUFFER_DEPTH))
    else $error("row buffer fill count beyond depth");

  // drain read index stays within the filled part
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= pending_count_q)
    else $error("drain index beyond buffer fill");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !any_load)
    else $error("output register loaded while stalled");

  // closing a row leaves an empty buffer and no held diagonal
  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.row_advance |=> (pending_count_q == '0) && !diag_valid_q)
    else $error("row state not cleared at row end");

endmodule

// ===== design/csr_block_diagonal_split.sv =====
// ----------------------------------------------------------------------------
// csr_block_diagonal_split
// streaming csr splitter into diagonal-block and rest matrices
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   ------------------------------------------
//   in        in_valid_i / in_stall_o command, column, value_real, value_imag
//   out       out_valid_o/out_stall_i kind, out_column, out_real, out_imag,
//                                     out_row, diag_count, rest_count, overflow,
//                                     last
//   cfg       cfg_we_i                cfg_wdata_i (block_size)
//
// an entry transaction is taken in the idle state; a rest entry is loaded into
// the output register at its accepting edge. a row end walks these steps in
// order: the accept, a diagonal slot whether or not a diagonal element is held,
// a ram read and an output load per buffered entry, a last read-index check and
// the summary load; the loads wait while the output register is stalled.
// reset clears the sequencer, row state and block size (to 1); the row buffer
// needs no clearing since only entries written in the current row are read.
// a stalled output register holds its result and blocks further loads.
// ----------------------------------------------------------------------------
module csr_block_diagonal_split
  import csr_bds_pkg::*;
#(
  parameter int unsigned ROW_BUFFER_DEPTH = DefRowBufferDepth,
  parameter int unsigned INDEX_BITS       = DefIndexBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [BsW-1:0]   cfg_wdata_i,
  // input transactions
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  input  logic [ColW-1:0]  column_i,
  input  logic [ValW-1:0]  value_real_i,
  input  logic [ValW-1:0]  value_imag_i,
  // result transactions
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [KindW-1:0] kind_o,
  output logic [ColW-1:0]  out_column_o,
  output logic [ValW-1:0]  out_real_o,
  output logic [ValW-1:0]  out_imag_o,
  output logic [RowW-1:0]  out_row_o,
  output logic [DcntW-1:0] diag_count_o,
  output logic [RcntW-1:0] rest_count_o,
  output logic             overflow_o,
  output logic             last_o
);

  // commands and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: entry acceptance and the row-end drain walk
  csr_bds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: classification, row buffer ram, counts and output register
  csr_bds_datapath #(
    .ROW_BUFFER_DEPTH (ROW_BUFFER_DEPTH),
    .INDEX_BITS       (INDEX_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .command_i    (command_i),
    .column_i     (column_i),
    .value_real_i (value_real_i),
    .value_imag_i (value_imag_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .kind_o       (kind_o),
    .out_column_o (out_column_o),
    .out_real_o   (out_real_o),
    .out_imag_o   (out_imag_o),
    .out_row_o    (out_row_o),
    .diag_count_o (diag_count_o),
    .rest_count_o (rest_count_o),
    .overflow_o   (overflow_o),
    .last_o       (last_o)
  );

endmodule
